@@ src/systolic_inversion_cell_top_macros.svh @@
// assertion macros for the systolic inversion cell
`ifndef SYSTOLIC_INVERSION_CELL_TOP_MACROS_SVH
`define SYSTOLIC_INVERSION_CELL_TOP_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define SIC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define SIC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/sic_pkg.sv @@
// ----------------------------------------------------------------------------
// sic_pkg
// Shared types, constants and float helpers for the systolic inversion cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package sic_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned MantW  = 24;

  localparam logic [WordW-1:0] CanonNan = 32'h7FC0_0000;
  localparam logic [WordW-1:0] FloatOne = 32'h3F80_0000;
  localparam logic [WordW-1:0] PosZero  = 32'h0000_0000;

  // operation codes for the shared unit
  localparam logic [1:0] OpDiv = 2'd0;
  localparam logic [1:0] OpMul = 2'd1;
  localparam logic [1:0] OpSub = 2'd2;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } fpu_ctl_t;

  typedef struct packed {
    logic done;
  } fpu_sts_t;

  function automatic logic is_nan(input logic [WordW-1:0] v);
    return (v[30:23] == 8'hFF) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic [WordW-1:0] canon(input logic [WordW-1:0] v);
    return is_nan(v) ? CanonNan : v;
  endfunction

endpackage
`default_nettype wire

@@ src/systolic_inversion_cell_top.sv @@
// ----------------------------------------------------------------------------
// systolic_inversion_cell_top
// One cell of a systolic matrix inversion array on single-precision floats.
// ----------------------------------------------------------------------------
//  channel   direction  signals
//  in_       input      in_valid, in_ready, in_x_value, in_y_value, in_load_factor
//  out_      output     out_valid, out_ready, out_x_passed, out_y_result, out_factor_now
//  cfg_      input      cfg_we, cfg_cell_kind
//
//  a load beat divides on the shared unit (one quotient bit a cycle in the divider)
//  an apply beat in an internal cell multiplies, then subtracts on the same unit; in a
//  boundary cell it only multiplies and negates; zero, infinite or NaN operands finish sooner
//  reset is synchronous; it clears the factor to +0 and the kind to internal
//  in_ready is low from acceptance until the result beat leaves the output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "systolic_inversion_cell_top_macros.svh"
module systolic_inversion_cell_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_cell_kind,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_x_value,
  input  wire logic [31:0] in_y_value,
  input  wire logic        in_load_factor,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_x_passed,
  output logic [31:0]      out_y_result,
  output logic [31:0]      out_factor_now
);
  import sic_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SLoad = 3'd1;
  localparam logic [2:0] SMul  = 3'd2;
  localparam logic [2:0] SSub  = 3'd3;
  localparam logic [2:0] SOut  = 3'd4;

  logic [2:0]  st_r, st_nxt;
  logic        kind_r;
  logic [31:0] factor_r, factor_nxt;
  logic [31:0] x_r, y_r, yres_r, yres_nxt;
  logic        load_r;
  logic        issue_r, issue_nxt;
  fpu_ctl_t    ctl;
  fpu_sts_t    sts;
  logic [31:0] fa, fb, fres;

  sic_fpu u_fpu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .op_a  (fa),
    .op_b  (fb),
    .sts   (sts),
    .res   (fres)
  );

  always_comb begin
    ctl.start = issue_r;
    ctl.op    = OpDiv;
    fa        = y_r;
    fb        = x_r;
    case (st_r)
      SLoad: begin
        ctl.op = OpDiv;
        fa     = kind_r ? FloatOne : y_r;
      end
      SMul: begin
        ctl.op = OpMul;
        fa     = factor_r;
      end
      SSub: begin
        ctl.op = OpSub;
        fb     = yres_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    st_nxt     = st_r;
    factor_nxt = factor_r;
    yres_nxt   = yres_r;
    issue_nxt  = 1'b0;
    unique case (st_r)
      SIdle: begin
        if (in_valid) begin
          st_nxt    = in_load_factor ? SLoad : SMul;
          issue_nxt = 1'b1;
        end
      end
      SLoad: begin
        if (sts.done) begin
          factor_nxt = fres;
          yres_nxt   = PosZero;
          st_nxt     = SOut;
        end
      end
      SMul: begin
        if (sts.done) begin
          yres_nxt = fres;
          if (kind_r) begin
            yres_nxt = is_nan(fres) ? CanonNan : {~fres[31], fres[30:0]};
            st_nxt   = SOut;
          end else begin
            st_nxt    = SSub;
            issue_nxt = 1'b1;
          end
        end
      end
      SSub: begin
        if (sts.done) begin
          yres_nxt = canon(fres);
          st_nxt   = SOut;
        end
      end
      SOut: begin
        if (out_ready) st_nxt = SIdle;
      end
      default: st_nxt = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= SIdle;
      kind_r   <= 1'b0;
      factor_r <= PosZero;
      issue_r  <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      factor_r <= factor_nxt;
      issue_r  <= issue_nxt;
      if (cfg_we) kind_r <= cfg_cell_kind;
    end
    yres_r <= yres_nxt;
    if (in_valid && in_ready) begin
      x_r    <= in_x_value;
      y_r    <= in_y_value;
      load_r <= in_load_factor;
    end
  end

  assign in_ready       = (st_r == SIdle);
  assign out_valid      = (st_r == SOut);
  assign out_x_passed   = x_r;
  assign out_y_result   = yres_r;
  assign out_factor_now = factor_r;

  `SIC_ASSERT_IMP(a_excl, in_ready, !out_valid, "ready and valid together")
  `SIC_ASSERT_IMP(a_load_zero, out_valid && load_r, out_y_result == PosZero, "load beat y not zero")
  `SIC_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_y_result), "result dropped")

endmodule
`default_nettype wire

@@ src/sic_fpu.sv @@
// ----------------------------------------------------------------------------
// sic_fpu
// Shared float unit: divide (one quotient bit a cycle), multiply, subtract.
// Round to nearest even, subnormals kept, NaN results canonical.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sic_fpu (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire sic_pkg::fpu_ctl_t       ctl,
  input  wire logic [31:0]             op_a,
  input  wire logic [31:0]             op_b,
  output sic_pkg::fpu_sts_t            sts,
  output logic [31:0]                  res
);
  import sic_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPrep  = 3'd1;
  localparam logic [2:0] StDiv   = 3'd2;
  localparam logic [2:0] StMul   = 3'd3;
  localparam logic [2:0] StNorm  = 3'd4;
  localparam logic [2:0] StRound = 3'd5;
  localparam logic [2:0] StDone  = 3'd6;

  logic [2:0]  st_r, st_nxt;
  logic [1:0]  op_r, op_nxt;
  logic [31:0] a_r, a_nxt, b_r, b_nxt;
  logic [31:0] res_r, res_nxt;
  logic        sign_r, sign_nxt;
  logic signed [10:0] exp_r, exp_nxt;
  // working significand: 50 bits including sticky
  logic [49:0] man_r, man_nxt;
  logic [25:0] rem_r, rem_nxt;
  logic [5:0]  cnt_r, cnt_nxt;

  // unpacked operands
  logic        sa, sb;
  logic [7:0]  ea, eb;
  logic [23:0] ma, mb;
  logic        za, zb, ia, ib, na, nb;
  logic signed [10:0] xa, xb;
  logic [4:0]  lza, lzb;
  logic [23:0] na_m, nb_m;

  // normalisation helpers
  logic [5:0]  lz;
  logic [49:0] shl;
  logic signed [10:0] e_adj;
  logic [5:0]  rsh;
  logic [49:0] shr_v;
  logic        shr_st;
  logic [24:0] rnd_m;
  logic        g, s, lsb, up;
  logic [8:0]  fexp;

  // subtraction path
  logic [7:0]  sub_ea, sub_eb;
  logic        sub_sa, sub_sb, sub_big;
  logic [7:0]  ed;
  logic [49:0] al_b, al_s;
  logic        al_st;
  logic [26:0] sm_big, sm_small;
  logic [27:0] sm_sum;

  function automatic logic [4:0] lead0_24(input logic [23:0] v);
    logic [4:0] n;
    n = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) n = 5'(23 - i);
    end
    return n;
  endfunction

  function automatic logic [5:0] lead0_50(input logic [49:0] v);
    logic [5:0] n;
    n = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

  always_comb begin
    sa = a_r[31]; sb = b_r[31];
    ea = a_r[30:23]; eb = b_r[30:23];
    ma = {(ea != 8'd0), a_r[22:0]};
    mb = {(eb != 8'd0), b_r[22:0]};
    za = (a_r[30:0] == 31'd0);
    zb = (b_r[30:0] == 31'd0);
    ia = (ea == 8'hFF) && (a_r[22:0] == 23'd0);
    ib = (eb == 8'hFF) && (b_r[22:0] == 23'd0);
    na = is_nan(a_r);
    nb = is_nan(b_r);
    lza = lead0_24(ma);
    lzb = lead0_24(mb);
    na_m = ma << lza;
    nb_m = mb << lzb;
    xa = 11'(signed'({3'd0, (ea == 8'd0) ? 8'd1 : ea})) - 11'(signed'({6'd0, lza}));
    xb = 11'(signed'({3'd0, (eb == 8'd0) ? 8'd1 : eb})) - 11'(signed'({6'd0, lzb}));
  end

  // normalise man_r so that bit 48 leads, exponent exp_r refers to bit 48
  always_comb begin
    lz    = lead0_50(man_r);
    shl   = (lz > 6'd1) ? (man_r << (lz - 6'd1)) : man_r;
    e_adj = (lz == 6'd0) ? exp_r + 11'sd1
          : exp_r - 11'(signed'({5'd0, lz})) + 11'sd1;
    if (lz == 6'd0) shl = {1'b0, man_r[49:2], |man_r[1:0]};
  end

  // rounding: man_r normalised, bit 48 leading
  always_comb begin
    if (exp_r < 11'sd1) begin
      rsh = (exp_r < -11'sd48) ? 6'd50 : 6'(11'sd1 - exp_r);
    end else begin
      rsh = 6'd0;
    end
    shr_v  = (rsh >= 6'd50) ? 50'd0 : (man_r >> rsh);
    shr_st = 1'b0;
    for (int i = 0; i < 50; i++) begin
      if (6'(i) < rsh && man_r[i]) shr_st = 1'b1;
    end
    g   = shr_v[24];
    s   = (|shr_v[23:0]) | shr_st;
    lsb = shr_v[25];
    up  = g & (s | lsb);
    rnd_m = {1'b0, shr_v[48:25]} + {24'd0, up};
    if (exp_r < 11'sd1) begin
      fexp = rnd_m[23] ? 9'd1 : 9'd0;
    end else begin
      fexp = 9'(exp_r) + {8'd0, rnd_m[24]};
    end
  end

  // subtraction alignment, guard and round bits kept beside the sticky
  always_comb begin
    sub_sa  = a_r[31];
    sub_sb  = ~b_r[31];
    sub_ea  = (ea == 8'd0) ? 8'd1 : ea;
    sub_eb  = (eb == 8'd0) ? 8'd1 : eb;
    sub_big = (sub_ea > sub_eb) || ((sub_ea == sub_eb) && (ma >= mb));
    ed      = sub_big ? sub_ea - sub_eb : sub_eb - sub_ea;
    al_b    = {(sub_big ? ma : mb), 26'd0};
    al_s    = {(sub_big ? mb : ma), 26'd0};
    al_st   = 1'b0;
    for (int i = 0; i < 50; i++) begin
      if (32'(i) < 32'(ed) && al_s[i]) al_st = 1'b1;
    end
    al_s     = (ed >= 8'd50) ? 50'd0 : (al_s >> ed);
    sm_big   = al_b[49:23];
    sm_small = {al_s[49:24], al_s[23] | (|al_s[22:0]) | al_st};
    sm_sum   = (sub_sa == sub_sb) ? {1'b0, sm_big} + {1'b0, sm_small}
             : {1'b0, sm_big} - {1'b0, sm_small};
  end

  always_comb begin
    st_nxt   = st_r;
    op_nxt   = op_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    res_nxt  = res_r;
    sign_nxt = sign_r;
    exp_nxt  = exp_r;
    man_nxt  = man_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    unique case (st_r)
      StIdle: begin
        if (ctl.start) begin
          op_nxt = ctl.op;
          a_nxt  = op_a;
          b_nxt  = op_b;
          st_nxt = StPrep;
        end
      end
      StPrep: begin
        st_nxt = StNorm;
        case (op_r)
          OpDiv: begin
            sign_nxt = sa ^ sb;
            if (na || nb || (za && zb) || (ia && ib)) begin
              res_nxt = CanonNan; st_nxt = StDone;
            end else if (ia || zb) begin
              res_nxt = {sa ^ sb, 31'h7F80_0000}; st_nxt = StDone;
            end else if (za || ib) begin
              res_nxt = {sa ^ sb, 31'd0}; st_nxt = StDone;
            end else begin
              // restoring divide, 26 quotient bits
              exp_nxt = xa - xb + 11'sd127;
              rem_nxt = {1'b0, na_m, 1'b0};
              a_nxt   = {8'd0, na_m};
              b_nxt   = {8'd0, nb_m};
              man_nxt = '0;
              cnt_nxt = 6'd26;
              st_nxt  = StDiv;
            end
          end
          OpMul: begin
            sign_nxt = sa ^ sb;
            if (na || nb || (ia && zb) || (za && ib)) begin
              res_nxt = CanonNan; st_nxt = StDone;
            end else if (ia || ib) begin
              res_nxt = {sa ^ sb, 31'h7F80_0000}; st_nxt = StDone;
            end else if (za || zb) begin
              res_nxt = {sa ^ sb, 31'd0}; st_nxt = StDone;
            end else begin
              exp_nxt = xa + xb - 11'sd127;
              a_nxt   = {8'd0, na_m};
              b_nxt   = {8'd0, nb_m};
              st_nxt  = StMul;
            end
          end
          default: begin
            // a - b
            if (na || nb || (ia && ib && (sa == b_r[31]))) begin
              res_nxt = CanonNan; st_nxt = StDone;
            end else if (ia) begin
              res_nxt = a_r; st_nxt = StDone;
            end else if (ib) begin
              res_nxt = {~b_r[31], b_r[30:0]}; st_nxt = StDone;
            end else begin
              sign_nxt = sub_big ? sub_sa : sub_sb;
              exp_nxt  = 11'(signed'({3'd0, sub_big ? sub_ea : sub_eb})) + 11'sd1;
              man_nxt  = {1'b0, sm_sum[27:0], 21'd0};
              if (sm_sum == 28'd0) begin
                // only minus zero less plus zero keeps the minus sign
                res_nxt = (za && zb) ? {sa & ~b_r[31], 31'd0} : PosZero;
                st_nxt  = StDone;
              end
            end
          end
        endcase
      end
      StDiv: begin
        // b_r holds the divisor significand, one quotient bit a cycle
        if (cnt_r != 6'd0) begin
          if (rem_r >= {1'b0, b_r[23:0], 1'b0}) begin
            rem_nxt = {rem_r - {1'b0, b_r[23:0], 1'b0}} << 1;
            man_nxt = {man_r[48:0], 1'b1};
          end else begin
            rem_nxt = rem_r << 1;
            man_nxt = {man_r[48:0], 1'b0};
          end
          cnt_nxt = cnt_r - 6'd1;
        end else begin
          // unit quotient bit lands on bit 49, one above the reference bit
          man_nxt = {man_r[25:0], 23'd0, (rem_r != 26'd0)};
          exp_nxt = exp_r - 11'sd1;
          st_nxt  = StNorm;
        end
      end
      StMul: begin
        man_nxt = {1'b0, 1'b0, 48'(a_r[23:0] * b_r[23:0])};
        exp_nxt = exp_r + 11'sd2;
        st_nxt  = StNorm;
      end
      StNorm: begin
        man_nxt = shl;
        exp_nxt = e_adj;
        st_nxt  = StRound;
      end
      StRound: begin
        if (fexp >= 9'd255) begin
          res_nxt = {sign_r, 31'h7F80_0000};
        end else begin
          res_nxt = {sign_r, fexp[7:0], rnd_m[22:0]};
        end
        st_nxt = StDone;
      end
      StDone: begin
        st_nxt = StIdle;
      end
      default: st_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= StIdle;
    end else begin
      st_r <= st_nxt;
    end
    op_r   <= op_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    res_r  <= res_nxt;
    sign_r <= sign_nxt;
    exp_r  <= exp_nxt;
    man_r  <= man_nxt;
    rem_r  <= rem_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign sts.done = (st_r == StDone);
  assign res      = res_r;

endmodule
`default_nettype wire
